FILE: hdl/i2c_master_bit_engine_macros.svh
// Assertion macros shared by the I2C master bit engine RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHECK_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/i2cmbe_pkg.sv
// Types and constants of the I2C master bit engine.
// No dependencies; imported by the top level.
`default_nettype none

package i2cmbe_pkg;

   localparam int STEP_W = 5;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_ACK   = 3'd4
   } opcode_type;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd1;
   localparam logic [STEP_W-1:0] STEP_SECOND   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_LAST_LOW = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LAST_BIT = 5'd14;
   localparam logic [STEP_W-1:0] STEP_RELEASE  = 5'd16;
   localparam logic [STEP_W-1:0] STEP_ACK_HIGH = 5'd17;
   localparam logic [STEP_W-1:0] STEP_ACK_LOW  = 5'd18;
   localparam logic [STEP_W-1:0] STEP_READ_END = 5'd16;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'h000b;

   // Result word, lowest bit last in this list.
   typedef struct packed {
      logic [1:0] pad;
      logic       ack_level;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       sda_level;
      logic       scl_level;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: hdl/i2c_master_bit_engine.sv
// I2C master bit engine: top level with tick sequencer and result register.
// Depends on i2cmbe_pkg and i2c_master_bit_engine_macros.svh.
//
// Each request is one timing tick: it carries the sampled SDA level and, while the
// engine is idle, an optional command (start, stop, write byte, read byte, send
// ack). Every accepted request yields exactly one response with the pin levels,
// busy/done flags, the receive byte and the last ack sample after that tick.
// Rate: one request per clock cycle unless the response port stalls. The tick sequencer
// updates in the cycle a request is accepted and the response lands in a single output
// register, so req_tready is high whenever that register is empty or is being drained
// in the same cycle; a stalled response port holds the engine until it takes the response.
// A half SCL period lasts csr_data ticks (reset 11, zero acts as one); write
// csr_data only while no command runs.
`default_nettype none

module i2c_master_bit_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] tx_byte, [8] sda_in, [15:9] zero
   input  wire logic [3:0]  req_tuser,  // [0] cmd_valid, [3:1] opcode
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,  // [0] scl_level, [1] sda_level, [2] sda_drive,
                                        // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                        // [13] ack_level, [15:14] zero
   // half period register
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_data
);
   import i2cmbe_pkg::*;

   // state registers
   logic [15:0]       half_period_ff, half_period_in;
   opcode_type        command_ff, command_in;
   logic [STEP_W-1:0] phase_ff, phase_in;
   logic [3:0]        bit_count_ff, bit_count_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        write_hold_ff, write_hold_in;
   logic [15:0]       tick_ff, tick_in;
   logic              pin_scl_ff, pin_scl_in;
   logic              pin_sda_ff, pin_sda_in;
   logic              pin_drive_ff, pin_drive_in;
   logic              ack_ff, ack_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   // request decode
   logic              req_accept;
   logic              line_sda;
   logic              cmd_offer;
   opcode_type        req_op;
   logic              cmd_ok;
   logic [15:0]       half_eff;
   logic [16:0]       tick_next;
   logic              finish;
   logic [3:0]        write_bits_expected;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign line_sda  = req_tdata[8];
   assign cmd_offer = req_tuser[0];
   assign req_op    = opcode_type'(req_tuser[3:1]);
   // Codes above send ack are dropped and leave the engine idle.
   assign cmd_ok    = cmd_offer && (req_op <= OP_ACK);

   // Zero in the register acts as a one-tick half period.
   assign half_eff  = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign tick_next = {1'b0, tick_ff} + 17'd1;

   always_comb begin
      half_period_in = half_period_ff;
      command_in     = command_ff;
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      write_hold_in  = write_hold_ff;
      tick_in        = tick_ff;
      pin_scl_in     = pin_scl_ff;
      pin_sda_in     = pin_sda_ff;
      pin_drive_in   = pin_drive_ff;
      ack_in         = ack_ff;
      finish         = 1'b0;

      if (csr_valid && csr_ready) begin
         half_period_in = csr_data;
      end

      if (req_accept) begin
         if (phase_ff == STEP_IDLE) begin
            // Latch a command and apply its first pin levels on this tick.
            if (cmd_ok) begin
               command_in = req_op;
               phase_in   = STEP_FIRST;
               tick_in    = 16'd0;
               case (req_op)
                  OP_START: begin
                     pin_scl_in   = 1'b1;
                     pin_sda_in   = 1'b1;
                     pin_drive_in = 1'b1;
                  end
                  OP_WRITE: begin
                     write_hold_in = req_tdata[7:0];
                     bit_count_in  = 4'd0;
                     pin_scl_in    = 1'b1;
                     pin_sda_in    = req_tdata[7];
                     pin_drive_in  = 1'b1;
                  end
                  OP_READ: begin
                     bit_count_in = 4'd0;
                     pin_scl_in   = 1'b1;
                     pin_sda_in   = 1'b1;
                     pin_drive_in = 1'b0;
                  end
                  default: begin
                     // stop and send ack both open with SDA low, SCL high
                     pin_scl_in   = 1'b1;
                     pin_sda_in   = 1'b0;
                     pin_drive_in = 1'b1;
                  end
               endcase
            end
         end else if (tick_next >= {1'b0, half_eff}) begin
            // End of a half period: advance the step.
            tick_in = 16'd0;
            case (command_ff)
               OP_START: begin
                  if (phase_ff == STEP_FIRST) begin
                     pin_scl_in = 1'b0;
                     phase_in   = STEP_SECOND;
                  end else begin
                     pin_sda_in = 1'b0;
                     finish     = 1'b1;
                  end
               end
               OP_STOP: begin
                  if (phase_ff == STEP_FIRST) begin
                     pin_sda_in = 1'b1;
                     phase_in   = STEP_SECOND;
                  end else begin
                     finish = 1'b1;
                  end
               end
               OP_ACK: begin
                  if (phase_ff == STEP_FIRST) begin
                     pin_scl_in = 1'b0;
                     phase_in   = STEP_SECOND;
                  end else begin
                     finish = 1'b1;
                  end
               end
               OP_WRITE: begin
                  if (phase_ff <= STEP_LAST_LOW && phase_ff[0]) begin
                     pin_scl_in = 1'b0;
                     phase_in   = phase_ff + 5'd1;
                  end else if (phase_ff <= STEP_LAST_BIT) begin
                     // next data bit, MSB first
                     bit_count_in  = bit_count_ff + 4'd1;
                     write_hold_in = {write_hold_ff[6:0], 1'b0};
                     pin_scl_in    = 1'b1;
                     pin_sda_in    = write_hold_ff[6];
                     pin_drive_in  = 1'b1;
                     phase_in      = phase_ff + 5'd1;
                  end else if (phase_ff == STEP_RELEASE) begin
                     // release SDA for the slave's ack
                     bit_count_in = bit_count_ff + 4'd1;
                     pin_scl_in   = 1'b1;
                     pin_sda_in   = 1'b1;
                     pin_drive_in = 1'b0;
                     phase_in     = STEP_ACK_HIGH;
                  end else if (phase_ff == STEP_ACK_HIGH) begin
                     ack_in     = line_sda;
                     pin_scl_in = 1'b0;
                     phase_in   = STEP_ACK_LOW;
                  end else begin
                     finish = 1'b1;
                  end
               end
               OP_READ: begin
                  if (phase_ff[0]) begin
                     // sample while SCL is high, then drop SCL
                     shift_in     = {shift_ff[6:0], line_sda};
                     bit_count_in = bit_count_ff + 4'd1;
                     pin_scl_in   = 1'b0;
                     phase_in     = phase_ff + 5'd1;
                  end else if (phase_ff < STEP_READ_END) begin
                     pin_scl_in = 1'b1;
                     phase_in   = phase_ff + 5'd1;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               phase_in = STEP_IDLE;
            end
         end else begin
            tick_in = tick_next[15:0];
         end
      end
   end

   // Response register: load on accept, drop when taken.
   always_comb begin
      rsp_data_in           = rsp_data_ff;
      rsp_tvalid_in         = rsp_tvalid_ff && !rsp_tready;
      if (req_accept) begin
         rsp_tvalid_in         = 1'b1;
         rsp_data_in.pad       = 2'b00;
         rsp_data_in.ack_level = ack_in;
         rsp_data_in.rx_byte   = shift_in;
         rsp_data_in.done_res  = finish;
         rsp_data_in.busy_res  = (phase_in != STEP_IDLE);
         rsp_data_in.sda_drive = pin_drive_in;
         rsp_data_in.sda_level = pin_sda_in;
         rsp_data_in.scl_level = pin_scl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         command_ff     <= OP_START;
         phase_ff       <= STEP_IDLE;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         write_hold_ff  <= 8'd0;
         tick_ff        <= 16'd0;
         pin_scl_ff     <= 1'b1;
         pin_sda_ff     <= 1'b1;
         pin_drive_ff   <= 1'b0;
         ack_ff         <= 1'b1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         half_period_ff <= half_period_in;
         command_ff     <= command_in;
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         write_hold_ff  <= write_hold_in;
         tick_ff        <= tick_in;
         pin_scl_ff     <= pin_scl_in;
         pin_sda_ff     <= pin_sda_in;
         pin_drive_ff   <= pin_drive_in;
         ack_ff         <= ack_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Bits sent so far during a write: half the step, one less on a low step.
   assign write_bits_expected = phase_ff[4:1] - {3'b000, ~phase_ff[0]};

   `include "i2c_master_bit_engine_macros.svh"

   `CHECK_HOLDS(a_write_bit_count, clock, reset,
      (command_ff == OP_WRITE) && (phase_ff != STEP_IDLE),
      bit_count_ff == write_bits_expected, "write bit count out of step")
   `CHECK_HOLDS(a_read_bit_count, clock, reset,
      (command_ff == OP_READ) && (phase_ff != STEP_IDLE),
      bit_count_ff == phase_ff[4:1], "read bit count out of step")
   `CHECK_HOLDS(a_tick_in_range, clock, reset, phase_ff != STEP_IDLE,
      tick_ff < half_eff, "tick counter past half period")
   `CHECK_HOLDS(a_done_not_busy, clock, reset, rsp_tvalid_ff && rsp_data_ff.done_res,
      !rsp_data_ff.busy_res, "completion reported as busy")
   `CHECK_NEXT(a_command_starts, clock, reset, req_accept && (phase_ff == STEP_IDLE) && cmd_ok,
      phase_ff == STEP_FIRST, "command not latched")

endmodule

`default_nettype wire
